// ----- rtl/fldx_pkg.sv -----
// Shared types, format codes and float helpers for the ldexp core.
// No dependencies; every rtl file refers to it by scoped name.
package fldx_pkg;

    // value format codes
    localparam logic [1:0] VF_F32  = 2'd0;
    localparam logic [1:0] VF_F64  = 2'd1;
    localparam logic [1:0] VF_F16  = 2'd2;
    localparam logic [1:0] VF_BF16 = 2'd3;

    // exponent format codes
    localparam logic [2:0] EF_I32  = 3'd0;
    localparam logic [2:0] EF_I64  = 3'd1;
    localparam logic [2:0] EF_F32  = 3'd2;
    localparam logic [2:0] EF_F16  = 3'd3;
    localparam logic [2:0] EF_BF16 = 3'd4;

    // configuration register indexes
    localparam logic CFG_VALUE_FORMAT    = 1'b0;
    localparam logic CFG_EXPONENT_FORMAT = 1'b1;

    // one classified request: x as binary32 and the integer exponent
    typedef struct packed {
        logic [31:0] xb;
        logic [31:0] n;
    } t_entry;

    // finite binary32 split into a normalised significand and biased exponent
    typedef struct packed {
        logic [23:0]        m;
        logic signed [9:0]  be0;
    } t_unpk;

    function automatic logic [4:0] lzc23(input logic [22:0] f);
        logic [4:0] lz;
        lz = 5'd23;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) begin
                lz = 5'(22 - i);
            end
        end
        return lz;
    endfunction

    // normalise a finite non-zero binary32; subnormals get a biased exponent <= 0
    function automatic t_unpk f32_unpack(input logic [31:0] b);
        t_unpk      u;
        logic [4:0] lz;
        lz = lzc23(b[22:0]);
        if (b[30:23] != 8'd0) begin
            u.m   = {1'b1, b[22:0]};
            u.be0 = $signed({2'b00, b[30:23]});
        end else begin
            u.m   = 24'({1'b0, b[22:0]} << (lz + 5'd1));
            u.be0 = -$signed({5'd0, lz});
        end
        return u;
    endfunction

    // Round a significand (leading one at bit 52) to nearest even and pack
    // exponent and fraction, right aligned, without the sign. Overflow gives
    // infinity; values below the normal range land in the subnormals.
    function automatic logic [62:0] round_pack(
        input logic [52:0]        m,
        input logic signed [34:0] be,
        input logic [5:0]         drop0,
        input logic [10:0]        emax,
        input logic [5:0]         mb
    );
        logic [106:0]       w;
        logic [6:0]         d;
        logic signed [35:0] k;
        logic [62:0]        base;
        logic [52:0]        kept;
        logic               rnd;
        logic [62:0]        res;
        k    = 36'sd1 - be;
        d    = 7'd0;
        base = 63'd0;
        w    = 107'd0;
        kept = 53'd0;
        rnd  = 1'b0;
        if (be >= $signed({24'd0, emax})) begin
            res = {52'd0, emax} << mb;
        end else begin
            if (be >= 35'sd1) begin
                d    = {1'b0, drop0};
                base = 63'(be - 35'sd1);
            end else if (k >= 36'sd64) begin
                d = 7'd127;
            end else begin
                d = {1'b0, drop0} + {1'b0, k[5:0]};
            end
            w    = {m, 54'd0} >> d;
            kept = w[106:54];
            rnd  = w[53] & ((|w[52:0]) | w[54]);
            res  = (base << mb) + {10'd0, kept} + {62'd0, rnd};
        end
        return res;
    endfunction

endpackage

// ----- rtl/float_ldexp_mixed_format_core.sv -----
// Top level of the mixed-format ldexp core: config registers, front end,
// request queue and back end. Uses fldx_pkg, fldx_front, fldx_queue, fldx_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   in       | i_in_valid / o_in_stall   | i_value_bits, i_exponent_bits
//   out      | o_out_valid / i_out_stall | o_result_bits
//   cfg      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while i_out_stall is low; a taken request is
// registered in the queue, then in the scaling stage, then in the format
// conversion stage, whose register drives the result.
// The two-entry queue absorbs back-end stalls; o_in_stall rises only when
// the queue is full. Synchronous active-low reset empties queue and stages
// and sets both formats to zero.
module float_ldexp_mixed_format_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value_bits,
    input  logic [63:0] i_exponent_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_bits
);

    logic [1:0]       r_value_format;
    logic [2:0]       r_exponent_format;
    fldx_pkg::t_entry d_entry;
    fldx_pkg::t_entry d_head;
    logic             d_full;
    logic             d_push;
    logic             d_q_valid;
    logic             d_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_format    <= fldx_pkg::VF_F32;
            r_exponent_format <= fldx_pkg::EF_I32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fldx_pkg::CFG_VALUE_FORMAT:    r_value_format    <= i_cfg_data[1:0];
                fldx_pkg::CFG_EXPONENT_FORMAT: r_exponent_format <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = d_full;
    assign d_push     = i_in_valid && !d_full;

    fldx_front u_front (
        .i_value_format    (r_value_format),
        .i_exponent_format (r_exponent_format),
        .i_value_bits      (i_value_bits),
        .i_exponent_bits   (i_exponent_bits),
        .o_entry           (d_entry)
    );

    fldx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (d_push),
        .i_data  (d_entry),
        .o_full  (d_full),
        .o_valid (d_q_valid),
        .o_data  (d_head),
        .i_pop   (d_pop)
    );

    fldx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value_format (r_value_format),
        .i_q_valid      (d_q_valid),
        .i_q_data       (d_head),
        .o_q_pop        (d_pop),
        .o_out_valid    (o_out_valid),
        .o_result_bits  (o_result_bits),
        .i_out_stall    (i_out_stall)
    );

endmodule

// ----- rtl/fldx_front.sv -----
// Front end: classifies a request, brings x to binary32 and the exponent
// operand to a 32-bit integer. Uses fldx_pkg.
module fldx_front (
    input  logic [1:0]     i_value_format,
    input  logic [2:0]     i_exponent_format,
    input  logic [63:0]    i_value_bits,
    input  logic [63:0]    i_exponent_bits,
    output fldx_pkg::t_entry o_entry
);

    // float exponent operand to int: truncate, saturate, NaN gives zero
    function automatic logic [31:0] fp_to_int(
        input logic       s,
        input logic [7:0] ex,
        input logic [7:0] emaxf,
        input logic [8:0] bias,
        input logic [22:0] frac
    );
        logic signed [9:0] e;
        logic [30:0]       mag;
        logic [31:0]       r;
        e   = $signed({2'b00, ex}) - $signed({1'b0, bias});
        mag = 31'd0;
        if (ex == emaxf) begin
            r = (frac != 23'd0) ? 32'd0 : (s ? 32'h8000_0000 : 32'h7fff_ffff);
        end else if (ex == 8'd0 || e < 10'sd0) begin
            r = 32'd0;
        end else if (e >= 10'sd31) begin
            r = s ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            mag = {1'b1, frac, 7'd0} >> (5'd30 - e[4:0]);
            r   = s ? -{1'b0, mag} : {1'b0, mag};
        end
        return r;
    endfunction

    logic [62:0]        d_rp;
    logic signed [34:0] d_be64;
    logic [4:0]         d_lz16;
    logic [31:0]        d_xb;
    logic [31:0]        d_n;
    logic [31:0]        d_b;

    assign d_be64 = $signed({24'd0, i_value_bits[62:52]}) - 35'sd896;
    assign d_rp   = fldx_pkg::round_pack({1'b1, i_value_bits[51:0]}, d_be64,
                                         6'd29, 11'd255, 6'd23);
    assign d_lz16 = fldx_pkg::lzc23({13'd0, i_value_bits[9:0]}) - 5'd13;

    always_comb begin
        d_b = (i_value_format == fldx_pkg::VF_BF16) ? {i_value_bits[15:0], 16'd0}
                                                   : i_value_bits[31:0];
        unique case (i_value_format)
            fldx_pkg::VF_F64: begin
                if (i_value_bits[62:52] == 11'h7ff) begin
                    d_xb = {i_value_bits[63], 8'hff,
                            (i_value_bits[51:29] | 23'h40_0000) & {23{|i_value_bits[51:0]}}};
                end else if (i_value_bits[62:52] == 11'd0) begin
                    // subnormal doubles lie far below the binary32 range
                    d_xb = {i_value_bits[63], 31'd0};
                end else begin
                    d_xb = {i_value_bits[63], d_rp[30:0]};
                end
            end
            fldx_pkg::VF_F16: begin
                if (i_value_bits[14:10] == 5'h1f) begin
                    d_xb = {i_value_bits[15], 8'hff,
                            (i_value_bits[9:0] == 10'd0) ? 23'd0
                                : {i_value_bits[9:0] | 10'h200, 13'd0}};
                end else if (i_value_bits[14:10] == 5'd0) begin
                    if (i_value_bits[9:0] == 10'd0) begin
                        d_xb = {i_value_bits[15], 31'd0};
                    end else begin
                        d_xb = {i_value_bits[15], 8'd112 - {3'd0, d_lz16},
                                10'(i_value_bits[9:0] << (d_lz16 + 5'd1)), 13'd0};
                    end
                end else begin
                    d_xb = {i_value_bits[15], {3'd0, i_value_bits[14:10]} + 8'd112,
                            i_value_bits[9:0], 13'd0};
                end
            end
            default: begin
                // f32 and bf16: exact, quiet any NaN
                if (d_b[30:23] == 8'hff && d_b[22:0] != 23'd0) begin
                    d_xb = {d_b[31:22] | 10'h001, d_b[21:0]};
                end else begin
                    d_xb = d_b;
                end
            end
        endcase
    end

    always_comb begin
        unique case (i_exponent_format)
            fldx_pkg::EF_F32:
                d_n = fp_to_int(i_exponent_bits[31], i_exponent_bits[30:23], 8'hff,
                                9'd127, i_exponent_bits[22:0]);
            fldx_pkg::EF_F16:
                d_n = fp_to_int(i_exponent_bits[15], {3'd0, i_exponent_bits[14:10]},
                                8'd31, 9'd15, {i_exponent_bits[9:0], 13'd0});
            fldx_pkg::EF_BF16:
                d_n = fp_to_int(i_exponent_bits[15], i_exponent_bits[14:7], 8'hff,
                                9'd127, {i_exponent_bits[6:0], 16'd0});
            default:
                d_n = i_exponent_bits[31:0];
        endcase
    end

    assign o_entry.xb = d_xb;
    assign o_entry.n  = d_n;

endmodule

// ----- rtl/fldx_queue.sv -----
// Two-entry request queue between front and back ends.
// Uses fldx_pkg for the entry type.
module fldx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fldx_pkg::t_entry i_data,
    output logic             o_full,
    output logic             o_valid,
    output fldx_pkg::t_entry o_data,
    input  logic             i_pop
);

    fldx_pkg::t_entry r_mem [2];
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             r_wr_ptr;
    logic             r_rd_ptr;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

// ----- rtl/fldx_back.sv -----
// Back end: scales binary32 x by 2^n, then converts to the value format.
// Two registered stages; uses fldx_pkg.
module fldx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_value_format,
    input  logic             i_q_valid,
    input  fldx_pkg::t_entry i_q_data,
    output logic             o_q_pop,
    output logic             o_out_valid,
    output logic [63:0]      o_result_bits,
    input  logic             i_out_stall
);

    logic               r_s1_valid;
    logic [31:0]        r_s1_yb;
    logic               r_out_valid;
    logic [63:0]        r_out;
    logic               d_out_ready;
    logic               d_s1_ready;

    fldx_pkg::t_unpk    d_ux;
    logic signed [34:0] d_be;
    logic [62:0]        d_rp1;
    logic [31:0]        d_yb;

    fldx_pkg::t_unpk    d_uy;
    logic [62:0]        d_rp16;
    logic [62:0]        d_rpb;
    logic [63:0]        d_res;
    logic [10:0]        d_e64;

    assign d_out_ready = !r_out_valid || !i_out_stall;
    assign d_s1_ready  = !r_s1_valid || d_out_ready;
    assign o_q_pop     = i_q_valid && d_s1_ready;

    // stage 1: scale
    assign d_ux  = fldx_pkg::f32_unpack(i_q_data.xb);
    assign d_be  = {{25{d_ux.be0[9]}}, d_ux.be0} + {{3{i_q_data.n[31]}}, i_q_data.n};
    assign d_rp1 = fldx_pkg::round_pack({d_ux.m, 29'd0}, d_be, 6'd29, 11'd255, 6'd23);

    always_comb begin
        // infinity, NaN and zero pass unchanged
        if (i_q_data.xb[30:23] == 8'hff || i_q_data.xb[30:0] == 31'd0) begin
            d_yb = i_q_data.xb;
        end else begin
            d_yb = {i_q_data.xb[31], d_rp1[30:0]};
        end
    end

    // stage 2: narrow or widen to the value format
    assign d_uy   = fldx_pkg::f32_unpack(r_s1_yb);
    assign d_rp16 = fldx_pkg::round_pack({d_uy.m, 29'd0},
                                         {{25{d_uy.be0[9]}}, d_uy.be0} - 35'sd112,
                                         6'd42, 11'd31, 6'd10);
    assign d_rpb  = fldx_pkg::round_pack({d_uy.m, 29'd0}, {{25{d_uy.be0[9]}}, d_uy.be0},
                                         6'd45, 11'd255, 6'd7);
    assign d_e64  = 11'($signed(d_uy.be0) + 10'sd0) + 11'd896;

    always_comb begin
        unique case (i_value_format)
            fldx_pkg::VF_F64: begin
                if (r_s1_yb[30:23] == 8'hff) begin
                    d_res = {r_s1_yb[31], 11'h7ff, r_s1_yb[22:0], 29'd0};
                end else if (r_s1_yb[30:0] == 31'd0) begin
                    d_res = {r_s1_yb[31], 63'd0};
                end else begin
                    d_res = {r_s1_yb[31], d_e64, d_uy.m[22:0], 29'd0};
                end
            end
            fldx_pkg::VF_F16: begin
                if (r_s1_yb[30:23] == 8'hff) begin
                    d_res = {48'd0, r_s1_yb[31], 5'h1f,
                             (r_s1_yb[22:0] == 23'd0) ? 10'd0
                                 : (r_s1_yb[22:13] | 10'h200)};
                end else if (r_s1_yb[30:0] == 31'd0) begin
                    d_res = {48'd0, r_s1_yb[31], 15'd0};
                end else begin
                    d_res = {48'd0, r_s1_yb[31], d_rp16[14:0]};
                end
            end
            fldx_pkg::VF_BF16: begin
                if (r_s1_yb[30:23] == 8'hff) begin
                    d_res = {48'd0, r_s1_yb[31], 8'hff,
                             (r_s1_yb[22:0] == 23'd0) ? 7'd0 : (r_s1_yb[22:16] | 7'h40)};
                end else if (r_s1_yb[30:0] == 31'd0) begin
                    d_res = {48'd0, r_s1_yb[31], 15'd0};
                end else begin
                    d_res = {48'd0, r_s1_yb[31], d_rpb[14:0]};
                end
            end
            default: begin
                d_res = {32'd0, r_s1_yb};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_yb <= d_yb;
        end
        if (r_s1_valid && d_out_ready) begin
            r_out <= d_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (d_s1_ready) begin
                r_s1_valid <= i_q_valid;
            end
            if (d_out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_bits = r_out;

endmodule

// ----- tb/tb_float_ldexp_mixed_format_core.sv -----
// Self-checking testbench for float_ldexp_mixed_format_core: scaling by powers of two
// over every value and exponent format. Depends on rtl/fldx_pkg.sv and the core RTL.
`timescale 1ns / 1ps
module tb_float_ldexp_mixed_format_core;

    typedef enum int {K_ZERO, K_FIN, K_INF, K_NAN} t_kind;
    typedef struct {
        t_kind       cls;
        bit          sgn;
        longint      ex;
        bit [63:0]   sig;
    } t_fnum;
    typedef struct {
        bit [63:0] vbits;
        bit [63:0] ebits;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_value_bits = 64'd0;
    logic [63:0] i_exponent_bits = 64'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_result_bits;

    t_req      pending_reqs[$];
    bit [63:0] scaled_expect[$];
    t_req      cur_req;
    bit [1:0]  cur_vf = fldx_pkg::VF_F32;
    bit [2:0]  cur_ef = fldx_pkg::EF_I32;
    bit        calm = 1'b0;
    int        gap = 0;
    int        burst = 0;
    int        hold_cnt = 0;
    bit        hold_done = 1'b0;
    int        n_taken = 0;
    int        n_checked = 0;
    int        errors = 0;
    int        idle_cycles = 0;

    float_ldexp_mixed_format_core u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void shape_of(input bit [1:0] f, output int eb, output int mb);
        case (f)
            fldx_pkg::VF_F64:  begin eb = 11; mb = 52; end
            fldx_pkg::VF_F16:  begin eb = 5;  mb = 10; end
            fldx_pkg::VF_BF16: begin eb = 8;  mb = 7;  end
            default: begin eb = 8;  mb = 23; end
        endcase
    endfunction

    function automatic t_fnum unpack_f(bit [63:0] b, int eb, int mb);
        t_fnum     r;
        bit [63:0] emax, exf, frac;
        longint    bias;
        emax = (64'd1 << eb) - 1;
        bias = (longint'(1) << (eb - 1)) - 1;
        exf  = (b >> mb) & emax;
        frac = b & ((64'd1 << mb) - 1);
        r.sgn = b[eb + mb];
        r.ex  = 0;
        r.sig = 0;
        if (exf == emax) begin
            r.cls = (frac != 0) ? K_NAN : K_INF;
            if (frac != 0) r.sig = frac << (64 - mb);
        end else if (exf == 0) begin
            if (frac == 0) begin
                r.cls = K_ZERO;
            end else begin
                r.cls = K_FIN;
                r.sig = frac << (63 - mb);
                r.ex  = 1 - bias;
                while (!r.sig[63]) begin
                    r.sig = r.sig << 1;
                    r.ex--;
                end
            end
        end else begin
            r.cls = K_FIN;
            r.sig = (frac | (64'd1 << mb)) << (63 - mb);
            r.ex  = longint'(exf) - bias;
        end
        return r;
    endfunction

    function automatic bit [63:0] pack_f(t_fnum v, int eb, int mb);
        longint    emax, bias, biased;
        bit [63:0] sbit, infb, kept, rem, half;
        int        sh;
        emax = (longint'(1) << eb) - 1;
        bias = (longint'(1) << (eb - 1)) - 1;
        sbit = 64'(v.sgn) << (eb + mb);
        infb = sbit | (64'(emax) << mb);
        if (v.cls == K_ZERO) return sbit;
        if (v.cls == K_INF) return infb;
        if (v.cls == K_NAN) return infb | (64'd1 << (mb - 1)) | (v.sig >> (64 - mb));
        biased = v.ex + bias;
        if (biased >= emax) return infb;
        if (biased >= 1) begin
            sh   = 63 - mb;
            kept = v.sig >> sh;
            rem  = v.sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0])) kept++;
            if (kept == (64'd1 << (mb + 1))) begin
                kept = kept >> 1;
                biased++;
                if (biased >= emax) return infb;
            end
            return sbit | (64'(biased) << mb) | (kept & ((64'd1 << mb) - 1));
        end
        // subnormal range
        if (longint'(63 - mb) + (1 - biased) > 64) return sbit;
        sh = int'(longint'(63 - mb) + (1 - biased));
        if (sh == 64) return sbit | ((v.sig > (64'd1 << 63)) ? 64'd1 : 64'd0);
        kept = v.sig >> sh;
        rem  = v.sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept++;
        return sbit | kept;
    endfunction

    // truncate toward zero, saturate to the 32-bit range
    function automatic longint trunc_to_int(t_fnum v);
        if (v.cls == K_NAN || v.cls == K_ZERO) return 0;
        if (v.cls == K_INF || v.ex >= 31) return v.sgn ? -64'sd2147483648 : 64'sd2147483647;
        if (v.ex < 0) return 0;
        return v.sgn ? -longint'(v.sig >> (63 - v.ex)) : longint'(v.sig >> (63 - v.ex));
    endfunction

    function automatic bit [63:0] ldexp_result(bit [63:0] vb, bit [63:0] ebits,
                                               bit [1:0] vf, bit [2:0] ef);
        int        eb, mb;
        longint    n;
        bit [63:0] wmask, xb;
        t_fnum     v;
        case (ef)
            fldx_pkg::EF_F32:  n = trunc_to_int(unpack_f(ebits & 64'hFFFF_FFFF, 8, 23));
            fldx_pkg::EF_F16:  n = trunc_to_int(unpack_f(ebits & 64'hFFFF, 5, 10));
            fldx_pkg::EF_BF16: n = trunc_to_int(unpack_f(ebits & 64'hFFFF, 8, 7));
            default: n = longint'($signed(ebits[31:0]));
        endcase
        shape_of(vf, eb, mb);
        wmask = (eb + mb + 1 >= 64) ? '1 : ((64'd1 << (eb + mb + 1)) - 1);
        v  = unpack_f(vb & wmask, eb, mb);
        xb = pack_f(v, 8, 23);
        v  = unpack_f(xb, 8, 23);
        if (v.cls == K_FIN) begin
            v.ex += n;
            v = unpack_f(pack_f(v, 8, 23), 8, 23);
        end
        return pack_f(v, eb, mb) & wmask;
    endfunction

    function automatic bit [63:0] pick_value(bit [1:0] vf);
        int        eb, mb, sel;
        longint    emax, bias, e;
        bit [63:0] r, wmask, frac;
        shape_of(vf, eb, mb);
        emax  = (longint'(1) << eb) - 1;
        bias  = (longint'(1) << (eb - 1)) - 1;
        r     = {$urandom, $urandom};
        wmask = (eb + mb + 1 >= 64) ? '1 : ((64'd1 << (eb + mb + 1)) - 1);
        frac  = {$urandom, $urandom} & ((64'd1 << mb) - 1);
        sel   = $urandom_range(0, 9);
        case (sel)
            0: begin e = 0; frac = 0; end
            1: e = 0;
            2: begin e = emax; frac = 0; end
            3: e = emax;
            4: return r;
            5, 6, 7: begin
                e = bias + $urandom_range(0, 300) - 150;
                if (e < 1) e = 1;
                if (e > emax - 1) e = emax - 1;
            end
            default: e = $urandom_range(1, int'(emax - 1));
        endcase
        return (r & ~wmask) | (64'($urandom_range(0, 1)) << (eb + mb))
             | (64'(e) << mb) | frac;
    endfunction

    function automatic bit [63:0] pick_exponent(bit [2:0] ef);
        bit [63:0] r;
        int        eb, mb, sel;
        longint    bias;
        r   = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel == 0) return r;
        if (ef == fldx_pkg::EF_F32 || ef == fldx_pkg::EF_F16 || ef == fldx_pkg::EF_BF16) begin
            shape_of((ef == fldx_pkg::EF_F32) ? fldx_pkg::VF_F32
                     : (ef == fldx_pkg::EF_F16) ? fldx_pkg::VF_F16 : fldx_pkg::VF_BF16,
                     eb, mb);
            bias = (longint'(1) << (eb - 1)) - 1;
            r[eb + mb] = $urandom_range(0, 1);
            if (sel == 1)
                r = r | (((64'd1 << eb) - 1) << mb);  // infinity or NaN
            else if (sel == 2)
                r = (r & ~(((64'd1 << eb) - 1) << mb))
                  | (64'(bias + $urandom_range(0, 40)) << mb);
            else
                r = (r & ~(((64'd1 << eb) - 1) << mb))
                  | (64'(bias - 2 + $urandom_range(0, 10)) << mb);
            return r;
        end
        if (sel == 1) r[31:0] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else r[31:0] = 32'($urandom_range(0, 400) - 200);
        return r;
    endfunction

    task automatic report_mismatch(input bit [63:0] got, input bit [63:0] want);
        $display("[%0t] result_bits mismatch: got %h, expected %h", $time, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || scaled_expect.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic queue_req(input bit [63:0] vb, input bit [63:0] ebits);
        t_req q;
        q.vbits = vb;
        q.ebits = ebits;
        pending_reqs.push_back(q);
    endtask

    // driver: present requests, random gaps, hold payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap        <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                scaled_expect.push_back(ldexp_result(i_value_bits, i_exponent_bits,
                                                     cur_vf, cur_ef));
                n_taken <= n_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap > 0) begin
                    gap        <= gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req         = pending_reqs.pop_front();
                    i_in_valid      <= 1'b1;
                    i_value_bits    <= cur_req.vbits;
                    i_exponent_bits <= cur_req.ebits;
                    if (!calm && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 15);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: random bursts plus one long hold-off to fill the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_taken >= 200) begin
            hold_done   <= 1'b1;
            hold_cnt    <= 79;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else if (burst > 0) begin
            burst       <= burst - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            burst       <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scaled_expect.size() == 0) begin
                $display("[%0t] unexpected result %h", $time, o_result_bits);
                errors++;
            end else begin
                if (o_result_bits !== scaled_expect[0])
                    report_mismatch(o_result_bits, scaled_expect[0]);
                void'(scaled_expect.pop_front());
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("watchdog expired with %0d results outstanding", scaled_expect.size());
            $display("float_ldexp_mixed_format_core regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: f32 value, i32 exponent (the reset formats)
        queue_req(64'h3F80_0000, 64'd0);
        queue_req(64'hDEAD_BEEF_3F80_0000, 64'd1);
        queue_req(64'h3F80_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(64'h3F80_0000, 64'd127);
        queue_req(64'h3F80_0000, 64'h0000_0000_FFFF_FF82);
        queue_req(64'h3F80_0000, 64'hFFFF_FFFF_FFFF_FF6B);
        queue_req(64'h3FC0_0000, 64'hFFFF_FFFF_FFFF_FF6A);
        queue_req(64'h3F80_0000, 64'h7FFF_FFFF);
        queue_req(64'h3F80_0000, 64'h1234_5678_8000_0000);
        queue_req(64'h0000_0001, 64'd0);
        queue_req(64'h0000_0001, 64'd1);
        queue_req(64'h0000_0003, 64'hFFFF_FFFF);
        queue_req(64'h7F7F_FFFF, 64'd1);
        queue_req(64'h7FC0_0001, 64'd5);
        queue_req(64'hFF80_0001, 64'd5);
        queue_req(64'h8000_0000, 64'd9);
        queue_req(64'hFF80_0000, 64'hFFFF_FFF0);
        queue_req(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        drain_all();

        // every value format against every exponent code, unknown codes included
        for (int ph = 0; ph < 32; ph++) begin
            if (ph >= 28) calm <= 1'b1;
            cur_vf = 2'(ph / 8);
            cur_ef = 3'(ph % 8);
            write_reg(fldx_pkg::CFG_VALUE_FORMAT, {1'b0, cur_vf});
            write_reg(fldx_pkg::CFG_EXPONENT_FORMAT, cur_ef);
            for (int k = 0; k < 18; k++)
                queue_req(pick_value(cur_vf), pick_exponent(cur_ef));
            drain_all();
        end

        $display("checked %0d results over 4 value formats and 8 exponent codes,", n_checked);
        $display("including specials, subnormals, saturation and a long output hold-off");
        if (errors == 0) begin
            $display("float_ldexp_mixed_format_core regression: pass");
        end else begin
            $display("float_ldexp_mixed_format_core regression: fail");
        end
        $finish;
    end

endmodule
